[hdl/stdp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STDP synapse package
// Widths and codes shared by the synapse weight update core and its checkers,
// plus the sequencer states and the weight saturation function of the core.
// ----------------------------------------------------------------------------
package stdp_pkg;

	// Synapse table geometry.
	localparam int SYNAPSES  = 1024;
	localparam int INDEX_W   = 10;
	localparam int WEIGHT_W  = 16;
	localparam int TIME_W    = 32;
	localparam int FRAC_W    = 12;

	// Configuration fields.
	localparam int FACTOR_W  = 16;
	localparam int WINDOW_W  = 31;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 31;

	// Shared multiplier operand and product widths.
	localparam int MULT_A_W  = WEIGHT_W + 2;
	localparam int MULT_B_W  = FACTOR_W + 1;
	localparam int PROD_W    = MULT_A_W + MULT_B_W;

	// Action codes of an input transaction.
	localparam logic [1:0] ACT_PRE  = 2'd0;
	localparam logic [1:0] ACT_POST = 2'd1;
	localparam logic [1:0] ACT_LOAD = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PLASTIC_EN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POT_STEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEP_STEP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd6;

	// Saturation limits of a weight, extended to product width.
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((1 << (WEIGHT_W - 1)) - 1);
	localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-(1 << (WEIGHT_W - 1)));

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_KMUL,
		S_UMUL,
		S_UPD,
		S_DONE
	} seq_state_t;

	// Clamp a wide signed value into the signed weight range.
	function automatic logic signed [WEIGHT_W-1:0] sat_weight(
		input logic signed [PROD_W-1:0] x
	);
		logic signed [WEIGHT_W-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[WEIGHT_W-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[WEIGHT_W-1:0];
		end else begin
			r = x[WEIGHT_W-1:0];
		end
		return r;
	endfunction

endpackage

[hdl/stdp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STDP generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module stdp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/stdp_synapse_weight_update_core.sv]
`timescale 1ns / 1ps
// A learning spike steps through S_DIFF, S_KMUL, S_UMUL, S_UPD and S_DONE; a load,
// a spike with plasticity off or an unused action goes from S_DIFF to S_DONE.
// S_DONE waits for a free output register; no new transaction is accepted until
// S_IDLE. One shared multiplier is used three times in sequence per update.
// Reset: arst_n clears the sequencer, output valid and configuration registers to
// their defaults; the weight and time memories are not cleared.
// ----------------------------------------------------------------------------
// STDP synapse weight update core
// Nearest-spike STDP with a soft upper bound on per-synapse signed Q4.12
// weights, driven by presynaptic, postsynaptic and load transactions.
// ----------------------------------------------------------------------------
module stdp_synapse_weight_update_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Configuration write port.
	input  logic                                     cfg_write,
	input  logic [stdp_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [stdp_pkg::CFG_DATA_W-1:0]          cfg_data,
	// Input channel.
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [1:0]                               action,
	input  logic [stdp_pkg::INDEX_W-1:0]             synapse_index,
	input  logic [stdp_pkg::TIME_W-1:0]              event_time,
	input  logic [stdp_pkg::TIME_W-1:0]              post_time,
	input  logic signed [stdp_pkg::WEIGHT_W-1:0]     load_weight,
	// Output channel.
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     drive_valid,
	output logic signed [stdp_pkg::WEIGHT_W-1:0]     drive_increment,
	output logic [stdp_pkg::INDEX_W-1:0]             synapse_out,
	output logic signed [stdp_pkg::WEIGHT_W-1:0]     new_weight,
	output logic                                     potentiated
);

	localparam int W  = stdp_pkg::WEIGHT_W;
	localparam int T  = stdp_pkg::TIME_W;
	localparam int F  = stdp_pkg::FACTOR_W;
	localparam int MA = stdp_pkg::MULT_A_W;
	localparam int MB = stdp_pkg::MULT_B_W;
	localparam int MP = stdp_pkg::PROD_W;

	stdp_pkg::seq_state_t state_q, state_d;

	// Configuration registers.
	logic                                  plastic_en_q;
	logic signed [W-1:0]                   weight_max_q;
	logic [F-1:0]                          drive_gain_q;
	logic [F-1:0]                          learn_rate_q;
	logic [F-1:0]                          pot_step_q;
	logic [F-1:0]                          dep_step_q;
	logic [stdp_pkg::WINDOW_W-1:0]         window_q;

	// Captured transaction.
	logic [1:0]                            action_q;
	logic [stdp_pkg::INDEX_W-1:0]          idx_q;
	logic [T-1:0]                          ev_time_q;
	logic [T-1:0]                          post_time_q;
	logic signed [W-1:0]                   load_w_q;

	// Working registers.
	logic signed [MP-1:0]                  prod_q;
	logic                                  pot_q;
	logic signed [W-1:0]                   drive_q;
	logic signed [W-1:0]                   nw_q;

	// Output register.
	logic                                  out_valid_q;
	logic                                  drive_valid_q;
	logic signed [W-1:0]                   drive_inc_q;
	logic [stdp_pkg::INDEX_W-1:0]          syn_out_q;
	logic signed [W-1:0]                   new_weight_q;
	logic                                  pot_out_q;

	// Memory ports.
	logic                                  rd_en;
	logic                                  w_we;
	logic                                  t_we;
	logic [W-1:0]                          w_rd;
	logic [T-1:0]                          t_rd;

	// Datapath signals.
	logic                                  accept;
	logic                                  out_free;
	logic                                  is_pre;
	logic                                  is_post;
	logic                                  is_load;
	logic                                  learn;
	logic signed [W-1:0]                   w_cur;
	logic signed [W:0]                     bound_gap;
	logic [T-1:0]                          time_b;
	logic [T-1:0]                          dt;
	logic                                  in_window;
	logic signed [MA-1:0]                  mult_a;
	logic signed [MB-1:0]                  mult_b;
	logic signed [MP-1:0]                  mult_p;
	logic signed [MP-1:0]                  upd_shift;
	logic signed [MP-1:0]                  w_ext;
	logic signed [MP-1:0]                  upd_sum;
	logic [F-1:0]                          k_factor;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign is_pre   = (action_q == stdp_pkg::ACT_PRE);
	assign is_post  = (action_q == stdp_pkg::ACT_POST);
	assign is_load  = (action_q == stdp_pkg::ACT_LOAD);
	assign learn    = plastic_en_q && (is_pre || is_post);

	// Weight and last presynaptic time memories.
	stdp_ram #(
		.WIDTH (W),
		.DEPTH (stdp_pkg::SYNAPSES)
	) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (idx_q),
		.wdata (nw_q),
		.re    (rd_en),
		.raddr (synapse_index),
		.rdata (w_rd)
	);

	stdp_ram #(
		.WIDTH (T),
		.DEPTH (stdp_pkg::SYNAPSES)
	) u_time_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (idx_q),
		.wdata (ev_time_q),
		.re    (rd_en),
		.raddr (synapse_index),
		.rdata (t_rd)
	);

	// Spike time distance, window compare and gap to the weight ceiling.
	assign w_cur     = $signed(w_rd);
	assign time_b    = is_pre ? post_time_q : t_rd;
	assign dt        = (ev_time_q >= time_b) ? (ev_time_q - time_b) : (time_b - ev_time_q);
	assign in_window = (dt < {1'b0, window_q});
	assign bound_gap = $signed({weight_max_q[W-1], weight_max_q}) - $signed({w_cur[W-1], w_cur});

	// Factor and weight update arithmetic on the registered product.
	assign k_factor  = prod_q[2*F-1:F];
	assign upd_shift = prod_q >>> F;
	assign w_ext     = MP'(w_cur);
	assign upd_sum   = pot_q ? (w_ext + upd_shift) : (w_ext - upd_shift);

	// Shared multiplier.
	assign mult_p = mult_a * mult_b;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plastic_en_q <= 1'b1;
			weight_max_q <= W'(4096);
			drive_gain_q <= F'(4096);
			learn_rate_q <= F'(655);
			pot_step_q   <= F'(6554);
			dep_step_q   <= F'(3277);
			window_q     <= stdp_pkg::WINDOW_W'(20000);
		end else if (cfg_write) begin
			unique case (cfg_index)
				stdp_pkg::REG_PLASTIC_EN: plastic_en_q <= cfg_data[0];
				stdp_pkg::REG_WEIGHT_MAX: weight_max_q <= $signed(cfg_data[W-1:0]);
				stdp_pkg::REG_DRIVE_GAIN: drive_gain_q <= cfg_data[F-1:0];
				stdp_pkg::REG_LEARN_RATE: learn_rate_q <= cfg_data[F-1:0];
				stdp_pkg::REG_POT_STEP:   pot_step_q   <= cfg_data[F-1:0];
				stdp_pkg::REG_DEP_STEP:   dep_step_q   <= cfg_data[F-1:0];
				stdp_pkg::REG_WINDOW:     window_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stdp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stdp_pkg::S_IDLE: if (accept) state_d = stdp_pkg::S_DIFF;
			stdp_pkg::S_DIFF: state_d = learn ? stdp_pkg::S_KMUL : stdp_pkg::S_DONE;
			stdp_pkg::S_KMUL: state_d = stdp_pkg::S_UMUL;
			stdp_pkg::S_UMUL: state_d = stdp_pkg::S_UPD;
			stdp_pkg::S_UPD:  state_d = stdp_pkg::S_DONE;
			stdp_pkg::S_DONE: if (out_free) state_d = stdp_pkg::S_IDLE;
			default:          state_d = stdp_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, memory enables and multiplier operands.
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		w_we     = 1'b0;
		t_we     = 1'b0;
		mult_a   = '0;
		mult_b   = '0;
		unique case (state_q)
			stdp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_valid;
			end
			stdp_pkg::S_DIFF: begin
				mult_a = MA'(w_cur);
				mult_b = $signed({1'b0, drive_gain_q});
			end
			stdp_pkg::S_KMUL: begin
				mult_a = $signed({2'b00, learn_rate_q});
				mult_b = $signed({1'b0, (pot_q ? pot_step_q : dep_step_q)});
			end
			stdp_pkg::S_UMUL: begin
				mult_a = pot_q ? MA'(bound_gap) : MA'(w_cur);
				mult_b = $signed({1'b0, k_factor});
			end
			stdp_pkg::S_UPD: ;
			stdp_pkg::S_DONE: begin
				w_we = out_free && (learn || is_load);
				t_we = out_free && ((is_pre && plastic_en_q) || is_load);
			end
			default: ;
		endcase
	end

	// Transaction capture and working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q    <= action;
			idx_q       <= synapse_index;
			ev_time_q   <= event_time;
			post_time_q <= post_time;
			load_w_q    <= load_weight;
		end
		prod_q <= mult_p;
		case (state_q)
			stdp_pkg::S_DIFF: begin
				if (learn) begin
					pot_q <= in_window;
				end else begin
					pot_q   <= 1'b0;
					nw_q    <= is_load ? load_w_q : w_cur;
					drive_q <= is_pre ? w_cur : '0;
				end
			end
			stdp_pkg::S_KMUL: begin
				drive_q <= is_pre ? stdp_pkg::sat_weight(prod_q >>> stdp_pkg::FRAC_W) : '0;
			end
			stdp_pkg::S_UPD: begin
				nw_q <= stdp_pkg::sat_weight(upd_sum);
			end
			default: ;
		endcase
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == stdp_pkg::S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == stdp_pkg::S_DONE && out_free) begin
			drive_valid_q <= is_pre;
			drive_inc_q   <= drive_q;
			syn_out_q     <= idx_q;
			new_weight_q  <= nw_q;
			pot_out_q     <= pot_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_valid     = drive_valid_q;
	assign drive_increment = drive_inc_q;
	assign synapse_out     = syn_out_q;
	assign new_weight      = new_weight_q;
	assign potentiated     = pot_out_q;

endmodule

[hdl/stdp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STDP core checker
// Port-level assertions on the synapse weight update core, bound to it.
// ----------------------------------------------------------------------------
module stdp_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic                                 drive_valid,
	input logic signed [stdp_pkg::WEIGHT_W-1:0] drive_increment,
	input logic [stdp_pkg::INDEX_W-1:0]         synapse_out,
	input logic signed [stdp_pkg::WEIGHT_W-1:0] new_weight,
	input logic                                 potentiated
);

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_weight) &&
		$stable(synapse_out) && $stable(drive_increment) && $stable(potentiated))
		else $error("stalled result changed");

	// After an input transaction the block is not ready in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on back-to-back cycles");

	// Without a drive request the increment is zero.
	a_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_valid |-> drive_increment == '0)
		else $error("drive increment set without drive request");

	// A new result appears only while the sequencer is busy.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result produced from idle");

endmodule

bind stdp_synapse_weight_update_core stdp_checker u_stdp_checker (.*);

[bench/synapse_update_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Synapse update checker
// Watches the configuration port and both channels of the STDP core, keeps
// its own copy of the weight and time tables, predicts the result of every
// accepted input transaction and compares each accepted result against it.
// ----------------------------------------------------------------------------
module synapse_update_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [stdp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [stdp_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic [1:0]                            action,
	input  logic [stdp_pkg::INDEX_W-1:0]          synapse_index,
	input  logic [stdp_pkg::TIME_W-1:0]           event_time,
	input  logic [stdp_pkg::TIME_W-1:0]           post_time,
	input  logic signed [stdp_pkg::WEIGHT_W-1:0]  load_weight,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic                                  drive_valid,
	input  logic signed [stdp_pkg::WEIGHT_W-1:0]  drive_increment,
	input  logic [stdp_pkg::INDEX_W-1:0]          synapse_out,
	input  logic signed [stdp_pkg::WEIGHT_W-1:0]  new_weight,
	input  logic                                  potentiated,
	output int                                    mismatches,
	output int                                    outstanding
);
	import stdp_pkg::*;

	typedef struct packed {
		logic                       drive_valid;
		logic signed [WEIGHT_W-1:0] drive_increment;
		logic [INDEX_W-1:0]         synapse_out;
		logic signed [WEIGHT_W-1:0] new_weight;
		logic                       potentiated;
	} synapse_result_t;

	// Results still owed by the core, oldest first.
	synapse_result_t expected_results[$];

	// Shadow synapse tables.
	logic signed [WEIGHT_W-1:0] weight_mem   [SYNAPSES];
	logic [TIME_W-1:0]          pre_time_mem [SYNAPSES];

	// Shadow configuration, starting at the reset values.
	logic                       plastic_on     = 1'b1;
	logic signed [WEIGHT_W-1:0] weight_ceiling = 16'sd4096;
	logic [FACTOR_W-1:0]        gain           = 16'd4096;
	logic [FACTOR_W-1:0]        rate           = 16'd655;
	logic [FACTOR_W-1:0]        pot_step       = 16'd6554;
	logic [FACTOR_W-1:0]        dep_step       = 16'd3277;
	logic [WINDOW_W-1:0]        window         = 31'd20000;

	int fail_count = 0;
	int in_flight  = 0;

	assign mismatches  = fail_count;
	assign outstanding = in_flight;

	// Clamp a wide value into the signed weight range.
	function automatic logic signed [WEIGHT_W-1:0] clamp_weight(input longint x);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (WEIGHT_W - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) begin
			return WEIGHT_W'(hi);
		end else if (x < lo) begin
			return WEIGHT_W'(lo);
		end
		return WEIGHT_W'(x);
	endfunction

	// One STDP step: pull toward the ceiling when the two spikes are close,
	// otherwise decay toward zero. Arithmetic shifts give floor rounding.
	function automatic logic signed [WEIGHT_W-1:0] stdp_adjust(
		input  logic signed [WEIGHT_W-1:0] w,
		input  logic [TIME_W-1:0]          ta,
		input  logic [TIME_W-1:0]          tb,
		output logic                       in_window
	);
		longint gap;
		longint k;
		longint wl;
		wl  = longint'(w);
		gap = (ta >= tb) ? longint'(ta - tb) : longint'(tb - ta);
		if (gap < longint'(window)) begin
			in_window = 1'b1;
			k = (longint'(rate) * longint'(pot_step)) >>> 16;
			return clamp_weight(wl + (((longint'(weight_ceiling) - wl) * k) >>> 16));
		end
		in_window = 1'b0;
		k = (longint'(rate) * longint'(dep_step)) >>> 16;
		return clamp_weight(wl - ((wl * k) >>> 16));
	endfunction

	// Work out the result of one input transaction and update the tables.
	function automatic synapse_result_t predict_update(
		input logic [1:0]                act,
		input logic [INDEX_W-1:0]        idx,
		input logic [TIME_W-1:0]         t_event,
		input logic [TIME_W-1:0]         t_post,
		input logic signed [WEIGHT_W-1:0] w_load
	);
		synapse_result_t r;
		logic signed [WEIGHT_W-1:0] w;
		logic hit;
		r             = '0;
		hit           = 1'b0;
		w             = weight_mem[idx];
		r.synapse_out = idx;
		r.new_weight  = w;
		case (act)
			ACT_PRE: begin
				r.drive_valid = 1'b1;
				if (plastic_on) begin
					r.drive_increment =
						clamp_weight((longint'(w) * longint'(gain)) >>> FRAC_W);
					r.new_weight       = stdp_adjust(w, t_event, t_post, hit);
					r.potentiated      = hit;
					weight_mem[idx]    = r.new_weight;
					pre_time_mem[idx]  = t_event;
				end else begin
					r.drive_increment = w;
				end
			end
			ACT_POST: begin
				if (plastic_on) begin
					r.new_weight    = stdp_adjust(w, t_event, pre_time_mem[idx], hit);
					r.potentiated   = hit;
					weight_mem[idx] = r.new_weight;
				end
			end
			ACT_LOAD: begin
				r.new_weight      = w_load;
				weight_mem[idx]   = w_load;
				pre_time_mem[idx] = t_event;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// Sample the ports at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		synapse_result_t want;
		if (!arst_n) begin
			plastic_on     = 1'b1;
			weight_ceiling = 16'sd4096;
			gain           = 16'd4096;
			rate           = 16'd655;
			pot_step       = 16'd6554;
			dep_step       = 16'd3277;
			window         = 31'd20000;
			expected_results.delete();
			in_flight      = 0;
		end else begin
			// Register writes.
			if (cfg_write) begin
				case (cfg_index)
					REG_PLASTIC_EN: plastic_on     = cfg_data[0];
					REG_WEIGHT_MAX: weight_ceiling = cfg_data[WEIGHT_W-1:0];
					REG_DRIVE_GAIN: gain           = cfg_data[FACTOR_W-1:0];
					REG_LEARN_RATE: rate           = cfg_data[FACTOR_W-1:0];
					REG_POT_STEP:   pot_step       = cfg_data[FACTOR_W-1:0];
					REG_DEP_STEP:   dep_step       = cfg_data[FACTOR_W-1:0];
					REG_WINDOW:     window         = cfg_data[WINDOW_W-1:0];
					default: begin
					end
				endcase
			end

			// Result transaction: compare against the oldest expectation.
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result for synapse %0d with nothing pending",
						synapse_out));
				end else begin
					want = expected_results.pop_front();
					if (drive_valid !== want.drive_valid)
						report_mismatch($sformatf("synapse %0d drive_valid got %0d want %0d",
							want.synapse_out, drive_valid, want.drive_valid));
					if (drive_increment !== want.drive_increment)
						report_mismatch($sformatf("synapse %0d drive_increment got %0d want %0d",
							want.synapse_out, drive_increment, want.drive_increment));
					if (synapse_out !== want.synapse_out)
						report_mismatch($sformatf("synapse_out got %0d want %0d",
							synapse_out, want.synapse_out));
					if (new_weight !== want.new_weight)
						report_mismatch($sformatf("synapse %0d new_weight got %0d want %0d",
							want.synapse_out, new_weight, want.new_weight));
					if (potentiated !== want.potentiated)
						report_mismatch($sformatf("synapse %0d potentiated got %0d want %0d",
							want.synapse_out, potentiated, want.potentiated));
				end
			end

			// Input transaction: predict its result.
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_update(action, synapse_index,
					event_time, post_time, load_weight));
			end

			in_flight = expected_results.size();
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STDP synapse core testbench
// Drives a short directed sequence and then randomized spike and load
// transactions through several register settings, with random idling on
// both channels, a long output stall and a drain pause. The checker does
// the prediction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import stdp_pkg::*;

	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam int SETTLE_CYCLES       = 8;
	localparam int HOLD_CYCLES         = 400;
	localparam int STALL_LIMIT         = 3000;
	localparam int PHASES              = 8;
	localparam int ITEMS_PER_PHASE     = 240;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_write;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [1:0]                 action;
	logic [INDEX_W-1:0]         synapse_index;
	logic [TIME_W-1:0]          event_time;
	logic [TIME_W-1:0]          post_time;
	logic signed [WEIGHT_W-1:0] load_weight;
	logic                       out_valid;
	logic                       out_ready;
	logic                       drive_valid;
	logic signed [WEIGHT_W-1:0] drive_increment;
	logic [INDEX_W-1:0]         synapse_out;
	logic signed [WEIGHT_W-1:0] new_weight;
	logic                       potentiated;
	int                         mismatches;
	int                         outstanding;

	// Stimulus-side view of the tables, used only to shape the items.
	bit                  loaded   [SYNAPSES];
	logic [TIME_W-1:0]   pre_hint [SYNAPSES];
	logic [INDEX_W-1:0]  hot_synapses [8] = '{10'd0, 10'd1, 10'd2, 10'd511,
		10'd512, 10'd513, 10'd1022, 10'd1023};
	logic [WINDOW_W-1:0] window_now  = 31'd20000;

	bit idle_on  = 1'b1;
	bit hold_off = 1'b0;
	int quiet_cycles = 0;

	stdp_synapse_weight_update_core DUT (.*);

	synapse_update_checker checker_i (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end else if (idle_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one input transaction and hold it until accepted. Called and
	// returning at a falling edge.
	task automatic send_item(
		input logic [1:0]                 act,
		input logic [INDEX_W-1:0]         idx,
		input logic [TIME_W-1:0]          t_event,
		input logic [TIME_W-1:0]          t_post,
		input logic signed [WEIGHT_W-1:0] w_load
	);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		synapse_index <= idx;
		event_time    <= t_event;
		post_time     <= t_post;
		load_weight   <= w_load;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (act == ACT_LOAD) begin
			loaded[idx]   = 1'b1;
			pre_hint[idx] = t_event;
		end else if (act == ACT_PRE) begin
			pre_hint[idx] = t_event;
		end
		@(negedge clk);
	endtask

	// Stop offering and wait until every result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	// Program every register; only called with the core idle.
	task automatic write_settings(
		input logic                pe,
		input logic [WEIGHT_W-1:0] wmax,
		input logic [FACTOR_W-1:0] gain,
		input logic [FACTOR_W-1:0] rate,
		input logic [FACTOR_W-1:0] pstep,
		input logic [FACTOR_W-1:0] dstep,
		input logic [WINDOW_W-1:0] win
	);
		write_reg(REG_PLASTIC_EN, CFG_DATA_W'(pe));
		write_reg(REG_WEIGHT_MAX, CFG_DATA_W'(wmax));
		write_reg(REG_DRIVE_GAIN, CFG_DATA_W'(gain));
		write_reg(REG_LEARN_RATE, CFG_DATA_W'(rate));
		write_reg(REG_POT_STEP,   CFG_DATA_W'(pstep));
		write_reg(REG_DEP_STEP,   CFG_DATA_W'(dstep));
		write_reg(REG_WINDOW,     CFG_DATA_W'(win));
		cfg_write   <= 1'b0;
		window_now  = win;
	endtask

	// Random transaction aimed mostly at a few busy synapses, with spike
	// time gaps mostly inside the coincidence window or on its edge.
	task automatic random_item();
		logic [INDEX_W-1:0]         idx;
		logic [1:0]                 act;
		logic [TIME_W-1:0]          base;
		logic [TIME_W-1:0]          other;
		logic [TIME_W-1:0]          delta;
		logic signed [WEIGHT_W-1:0] w_load;
		int pick;
		if ($urandom_range(0, 9) < 7) begin
			idx = hot_synapses[$urandom_range(0, 7)];
		end else begin
			idx = INDEX_W'($urandom);
		end
		pick = $urandom_range(0, 99);
		if (!loaded[idx]) begin
			act = ACT_LOAD;
		end else if (pick < 40) begin
			act = ACT_PRE;
		end else if (pick < 72) begin
			act = ACT_POST;
		end else if (pick < 93) begin
			act = ACT_LOAD;
		end else begin
			act = ACT_UNUSED;
		end
		case ($urandom_range(0, 5))
			0: delta = TIME_W'(window_now);
			1: delta = (window_now == 0) ? '0 : TIME_W'(window_now - 1);
			2: delta = $urandom;
			default: delta = (window_now == 0) ? '0 :
				TIME_W'($urandom_range(0, 32'(window_now) - 1));
		endcase
		base  = (act == ACT_POST) ? pre_hint[idx] : $urandom;
		other = ($urandom_range(0, 1) == 1) ? base + delta : base - delta;
		case ($urandom_range(0, 5))
			0: w_load = 16'sh7FFF;
			1: w_load = 16'sh8000;
			2: w_load = WEIGHT_W'($urandom_range(0, 8192));
			default: w_load = WEIGHT_W'($urandom);
		endcase
		if (act == ACT_POST) begin
			send_item(act, idx, other, $urandom, w_load);
		end else begin
			send_item(act, idx, base, other, w_load);
		end
	endtask

	// Main stimulus.
	initial begin
		int p;
		int n;
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		action        = ACT_PRE;
		synapse_index = '0;
		event_time    = '0;
		post_time     = '0;
		load_weight   = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset settings: extreme weights and times,
		// spikes exactly on and just inside the window edge, the unused code.
		send_item(ACT_LOAD, 10'd0,    32'd0,          32'd0,      16'sh7FFF);
		send_item(ACT_LOAD, 10'd1023, 32'hFFFF_FFFF,  32'd0,      16'sh8000);
		send_item(ACT_LOAD, 10'd5,    32'd1000,       32'd0,      16'sd0);
		send_item(ACT_LOAD, 10'd6,    32'd50000,      32'd0,      16'sd4096);
		send_item(ACT_PRE,  10'd0,    32'd100,        32'd100,    16'sd0);
		send_item(ACT_PRE,  10'd1023, 32'hFFFF_FFFF,  32'd0,      16'sd0);
		send_item(ACT_PRE,  10'd5,    32'd20000,      32'd0,      16'sd0);
		send_item(ACT_PRE,  10'd6,    32'd50000,      32'd30001,  16'sd0);
		send_item(ACT_POST, 10'd0,    32'd200,        32'd0,      16'sd0);
		send_item(ACT_POST, 10'd1023, 32'd0,          32'd0,      16'sd0);
		send_item(ACT_POST, 10'd6,    32'd70000,      32'd0,      16'sd0);
		send_item(ACT_UNUSED, 10'd5,  32'hFFFF_FFFF,  32'hFFFF_FFFF, 16'shFFFF);
		send_item(ACT_LOAD, 10'd6,    32'd0,          32'd0,      -16'sd1);
		send_item(ACT_PRE,  10'd6,    32'd5,          32'd10,     16'sd0);
		send_item(ACT_POST, 10'd6,    32'd0,          32'd0,      16'sd0);

		// Plasticity off: raw weight drive, no learning.
		wait_drained();
		write_settings(1'b0, 16'd4096, 16'd4096, 16'd655, 16'd6554, 16'd3277, 31'd20000);
		send_item(ACT_PRE,  10'd0,    32'd300,        32'd300,    16'sd0);
		send_item(ACT_POST, 10'd0,    32'd300,        32'd0,      16'sd0);
		send_item(ACT_PRE,  10'd1023, 32'd0,          32'd0,      16'sd0);
		send_item(ACT_LOAD, 10'd3,    32'd7,          32'd0,      16'sd1234);
		send_item(ACT_UNUSED, 10'd3,  32'd0,          32'd0,      16'sd0);

		// Largest gains, rates and window.
		wait_drained();
		write_settings(1'b1, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF);
		send_item(ACT_PRE,  10'd0,    32'd0,          32'hFFFF_FFFF, 16'sd0);
		send_item(ACT_PRE,  10'd1023, 32'd0,          32'd0,      16'sd0);
		send_item(ACT_POST, 10'd1023, 32'hFFFF_FFFF,  32'd0,      16'sd0);
		send_item(ACT_POST, 10'd0,    32'd12345,      32'd0,      16'sd0);

		// Random phases, each under its own register setting.
		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			idle_on = (p != 3) && (p != PHASES - 1);
			case (p)
				0: write_settings(1'b1, 16'd4096, 16'd4096, 16'd655, 16'd6554, 16'd3277,
					31'd20000);
				1: write_settings(1'b1, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					31'h7FFF_FFFF);
				2: write_settings(1'b1, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 31'd0);
				3: write_settings(1'b1, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0,
					31'd1000);
				4: write_settings(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 31'($urandom_range(0, 100000)));
				PHASES - 1: write_settings(1'b1, 16'($urandom_range(0, 8192)), 16'd4096,
					16'($urandom), 16'($urandom), 16'($urandom),
					31'($urandom_range(1000, 50000)));
				default: write_settings(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 31'($urandom_range(0, 100000)));
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Long output stall while items keep coming, so the input backs up.
				if (p == 1 && n == 60) begin
					hold_off = 1'b1;
				end
				// Sender pause until the core has delivered everything.
				if (p == 5 && n == ITEMS_PER_PHASE / 2) begin
					wait_drained();
				end
				random_item();
			end
		end

		// Wind down and give the verdict.
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[files.f]
hdl/stdp_pkg.sv
hdl/stdp_ram.sv
hdl/stdp_synapse_weight_update_core.sv
hdl/stdp_checker.sv
bench/synapse_update_checker.sv
bench/testbench.sv
